### rtl/crp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crp_pkg
// Shared types and constants of the chunk request parser: message layout,
// result kinds, status codes and the result word.
// ----------------------------------------------------------------------------
package crp_pkg;

  localparam int HASH_BYTES = 20;
  localparam int MAX_CHUNKS = 1024;

  // Header layout, byte offsets of each field start.
  localparam int OFS_PREV  = 16;
  localparam int OFS_INDEX = 32;
  localparam int OFS_HASH  = 36;
  localparam int OFS_NAME  = OFS_HASH + HASH_BYTES;
  localparam int OFS_ADDR  = OFS_NAME + 31;
  localparam int OFS_PORT  = OFS_ADDR + 4;
  localparam int HDR_BYTES = OFS_PORT + 2;
  localparam int ID_BYTES  = OFS_INDEX;

  localparam int POS_W   = 7;
  localparam int TOTAL_W = 11;

  typedef enum logic [3:0] {
    KIND_ID      = 4'd0,
    KIND_PREV_ID = 4'd1,
    KIND_INDEX   = 4'd2,
    KIND_HASH    = 4'd3,
    KIND_NAME    = 4'd4,
    KIND_ADDR    = 4'd5,
    KIND_PORT    = 4'd6,
    KIND_RUN     = 4'd7,
    KIND_STATUS  = 4'd8
  } kind_t;

  typedef enum logic [1:0] {
    ST_SHORT    = 2'd0,
    ST_IDS_ONLY = 2'd1,
    ST_PARTIAL  = 2'd2,
    ST_COMPLETE = 2'd3
  } status_t;

  typedef struct packed {
    kind_t                kind;
    logic [1:0]           word_index;
    logic [63:0]          value;
    logic [8:0]           run_count;
    status_t              status;
    logic [TOTAL_W-1:0]   chunk_total;
    logic                 last_of_msg;
  } result_t;

  // Up to two results per accepted byte; the second is present only with the first.
  typedef struct packed {
    logic    v0;
    result_t r0;
    logic    v1;
    result_t r1;
  } push_t;

endpackage

### rtl/crp_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crp_parse
// Byte-step parser: holds the message state and forms the results caused
// by the byte being accepted.
// ----------------------------------------------------------------------------
module crp_parse (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          byte_in,
  input  logic                end_of_msg,
  output crp_pkg::push_t      push
);

  logic [crp_pkg::POS_W-1:0]   byte_position;
  logic [63:0]                 word_assembler;
  logic [2:0]                  entry_byte_count;
  logic [31:0]                 entry_start;
  logic [crp_pkg::TOTAL_W-1:0] chunks_accepted;

  logic                        in_header;
  crp_pkg::kind_t              fkind;
  logic [crp_pkg::POS_W-1:0]   fstart;
  logic [crp_pkg::POS_W-1:0]   fend;
  logic [crp_pkg::POS_W-1:0]   foff;
  logic [crp_pkg::POS_W-1:0]   pos_inc;
  logic                        word_done;
  logic [63:0]                 assembled;
  logic [31:0]                 start_merged;
  logic [8:0]                  run_len;
  logic [crp_pkg::TOTAL_W-1:0] room;
  logic [crp_pkg::TOTAL_W-1:0] clipped;
  logic                        below_cap;
  logic                        run_emit;
  logic [crp_pkg::TOTAL_W-1:0] chunks_next;
  logic [crp_pkg::POS_W-1:0]   seen;
  crp_pkg::status_t            st;
  logic                        has_a;
  crp_pkg::result_t            item_a;
  crp_pkg::result_t            item_s;

  assign in_header = byte_position < crp_pkg::POS_W'(crp_pkg::HDR_BYTES);
  assign pos_inc   = byte_position + crp_pkg::POS_W'(1);

  always_comb begin
    if (byte_position < crp_pkg::POS_W'(crp_pkg::OFS_PREV)) begin
      fkind = crp_pkg::KIND_ID;
      fstart = '0;
      fend = crp_pkg::POS_W'(crp_pkg::OFS_PREV);
    end else if (byte_position < crp_pkg::POS_W'(crp_pkg::OFS_INDEX)) begin
      fkind = crp_pkg::KIND_PREV_ID;
      fstart = crp_pkg::POS_W'(crp_pkg::OFS_PREV);
      fend = crp_pkg::POS_W'(crp_pkg::OFS_INDEX);
    end else if (byte_position < crp_pkg::POS_W'(crp_pkg::OFS_HASH)) begin
      fkind = crp_pkg::KIND_INDEX;
      fstart = crp_pkg::POS_W'(crp_pkg::OFS_INDEX);
      fend = crp_pkg::POS_W'(crp_pkg::OFS_HASH);
    end else if (byte_position < crp_pkg::POS_W'(crp_pkg::OFS_NAME)) begin
      fkind = crp_pkg::KIND_HASH;
      fstart = crp_pkg::POS_W'(crp_pkg::OFS_HASH);
      fend = crp_pkg::POS_W'(crp_pkg::OFS_NAME);
    end else if (byte_position < crp_pkg::POS_W'(crp_pkg::OFS_ADDR)) begin
      fkind = crp_pkg::KIND_NAME;
      fstart = crp_pkg::POS_W'(crp_pkg::OFS_NAME);
      fend = crp_pkg::POS_W'(crp_pkg::OFS_ADDR);
    end else if (byte_position < crp_pkg::POS_W'(crp_pkg::OFS_PORT)) begin
      fkind = crp_pkg::KIND_ADDR;
      fstart = crp_pkg::POS_W'(crp_pkg::OFS_ADDR);
      fend = crp_pkg::POS_W'(crp_pkg::OFS_PORT);
    end else begin
      fkind = crp_pkg::KIND_PORT;
      fstart = crp_pkg::POS_W'(crp_pkg::OFS_PORT);
      fend = crp_pkg::POS_W'(crp_pkg::HDR_BYTES);
    end
  end

  assign foff      = byte_position - fstart;
  assign word_done = (foff[2:0] == 3'd7) || (pos_inc == fend);
  assign assembled = word_assembler | ({56'b0, byte_in} << {foff[2:0], 3'b000});

  // Run entries: four start bytes, then the count byte.
  assign start_merged = entry_start | ({24'b0, byte_in} << {entry_byte_count[1:0], 3'b000});
  assign run_len      = {1'b0, byte_in} + 9'd1;
  assign below_cap    = chunks_accepted < crp_pkg::TOTAL_W'(crp_pkg::MAX_CHUNKS);
  assign room         = crp_pkg::TOTAL_W'(crp_pkg::MAX_CHUNKS) - chunks_accepted;
  assign clipped      = ({2'b0, run_len} > room) ? room : {2'b0, run_len};
  assign run_emit     = !in_header && (entry_byte_count == 3'd4) && below_cap;
  assign chunks_next  = run_emit ? chunks_accepted + clipped : chunks_accepted;

  assign seen = in_header ? pos_inc : crp_pkg::POS_W'(crp_pkg::HDR_BYTES + 1);

  always_comb begin
    if (seen < crp_pkg::POS_W'(crp_pkg::ID_BYTES)) begin
      st = crp_pkg::ST_SHORT;
    end else if (seen == crp_pkg::POS_W'(crp_pkg::ID_BYTES)) begin
      st = crp_pkg::ST_IDS_ONLY;
    end else if (seen < crp_pkg::POS_W'(crp_pkg::HDR_BYTES)) begin
      st = crp_pkg::ST_PARTIAL;
    end else begin
      st = crp_pkg::ST_COMPLETE;
    end
  end

  always_comb begin
    has_a               = in_header ? word_done : run_emit;
    item_a.kind         = in_header ? fkind : crp_pkg::KIND_RUN;
    item_a.word_index   = in_header ? foff[4:3] : 2'd0;
    item_a.value        = in_header ? assembled : {32'b0, entry_start};
    item_a.run_count    = in_header ? 9'd0 : clipped[8:0];
    item_a.status       = crp_pkg::ST_SHORT;
    item_a.chunk_total  = chunks_next;
    item_a.last_of_msg  = 1'b0;

    item_s.kind         = crp_pkg::KIND_STATUS;
    item_s.word_index   = 2'd0;
    item_s.value        = '0;
    item_s.run_count    = 9'd0;
    item_s.status       = st;
    item_s.chunk_total  = chunks_next;
    item_s.last_of_msg  = 1'b1;

    push.v0 = step && (has_a || end_of_msg);
    push.r0 = has_a ? item_a : item_s;
    push.v1 = step && has_a && end_of_msg;
    push.r1 = item_s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      word_assembler   <= '0;
      entry_byte_count <= '0;
      entry_start      <= '0;
      chunks_accepted  <= '0;
    end else if (step) begin
      if (end_of_msg) begin
        byte_position    <= '0;
        word_assembler   <= '0;
        entry_byte_count <= '0;
        entry_start      <= '0;
        chunks_accepted  <= '0;
      end else if (in_header) begin
        byte_position  <= pos_inc;
        word_assembler <= word_done ? 64'd0 : assembled;
      end else begin
        if (entry_byte_count < 3'd4) begin
          entry_start      <= start_merged;
          entry_byte_count <= entry_byte_count + 3'd1;
        end else begin
          entry_start      <= '0;
          entry_byte_count <= '0;
        end
        chunks_accepted <= chunks_next;
      end
    end
  end

endmodule

### rtl/crp_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crp_outq
// Three-word result queue: takes up to two words per cycle, hands one out
// per cycle from its head register while out_ready is high.
// ----------------------------------------------------------------------------
module crp_outq (
  input  logic              clk,
  input  logic              rst,
  input  crp_pkg::push_t    push,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output crp_pkg::result_t  out_item
);

  crp_pkg::result_t slot      [0:2];
  crp_pkg::result_t slot_next [0:2];
  logic [1:0]       count;
  logic [1:0]       count_next;
  logic [1:0]       kept;
  logic             pop;

  assign out_valid = count != 2'd0;
  assign out_item  = slot[0];
  assign pop       = out_valid && out_ready;
  // Two free places are needed for a byte that yields two words.
  assign room      = count <= 2'd1;
  assign kept      = count - {1'b0, pop};

  always_comb begin
    slot_next[0] = slot[0];
    slot_next[1] = slot[1];
    slot_next[2] = slot[2];
    if (pop) begin
      slot_next[0] = slot[1];
      slot_next[1] = slot[2];
    end
    if (push.v0) begin
      slot_next[kept] = push.r0;
    end
    if (push.v1) begin
      slot_next[kept + 2'd1] = push.r1;
    end
    count_next = kept + {1'b0, push.v0} + {1'b0, push.v1};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    slot[0] <= slot_next[0];
    slot[1] <= slot_next[1];
    slot[2] <= slot_next[2];
  end

endmodule

### rtl/chunk_request_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunk_request_parser
// Byte-stream parser of a file-transfer request: emits header fields as
// 64-bit words, capped run entries, and a status word per message.
// ----------------------------------------------------------------------------
// Feed one message byte per word on s_*, s_tlast on the final byte. The
// parser takes one byte every cycle while s_tready is high: each byte updates
// the counters and the word assembler, and its results go straight into a
// three-word output queue, so s_tready stays high while at most one result
// waits on m_*. The output side hands out one result per cycle while m_tready
// is high, so the sustained rate is one byte per clock; a final byte that also
// completes a field word or a run yields two results and may stall the input.
// Header words come out in message order (ids, file index, hash, name,
// address, port), each run entry before the cap is reached yields one run
// word with its count clipped to the chunk cap, and the final byte always
// ends with a status word carrying m_tlast. On a partial-body status, discard
// the header words already delivered for that message.
module chunk_request_parser (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] byte_in
  input  logic         s_tlast,   // end_of_msg
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [87:0]  m_tdata,   // [1:0] word_index, [65:2] value, [74:66] run_count,
                                  // [76:75] status, [87:77] chunk_total
  output logic [3:0]   m_tuser,   // [3:0] kind
  output logic         m_tlast    // last_of_msg
);

  logic              take;
  crp_pkg::push_t    push;
  crp_pkg::result_t  head;

  // Advance the parser only on an accepted byte.
  assign take = s_tvalid && s_tready;

  crp_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .step       (take),
    .byte_in    (s_tdata),
    .end_of_msg (s_tlast),
    .push       (push)
  );

  crp_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_item  (head)
  );

  // Pack the head result onto the master side.
  assign m_tdata = {head.chunk_total, head.status, head.run_count, head.value,
                    head.word_index};
  assign m_tuser = head.kind;
  assign m_tlast = head.last_of_msg;

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the chunk request parser. Streams request messages
// byte by byte (short, ids-only, partial, complete, with and without run
// entries, cap-reaching runs, trailing partial entries), predicts every
// result word from a cycle-free model of the parser, and checks each output
// word field by field under several source/sink idling mixes.
// ----------------------------------------------------------------------------
module tb_top;
  import crp_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int LONG_HOLD      = 400;
  localparam int PHASE_BYTES    = 85;
  localparam int REPORT_MAX     = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       eom;
  } msg_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [87:0] m_tdata;
  logic [3:0]  m_tuser;
  logic        m_tlast;

  chunk_request_parser i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // Bytes waiting to be offered, and result words still owed by the parser.
  msg_byte_t pending_bytes[$];
  result_t   expected_words[$];

  // Idling mix of the current phase, in percent.
  int src_idle_pct = 0;
  int dst_stall_pct = 0;

  // Long sink hold-off: bump hold_req to start one.
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // Shadow parser state.
  int unsigned hdr_pos = 0;
  logic [63:0] word_acc = '0;
  int unsigned entry_bytes = 0;
  logic [31:0] entry_addr = '0;
  int unsigned chunk_sum = 0;

  // Bookkeeping.
  int fail_cnt = 0;
  int words_checked = 0;
  int msgs_sent = 0;
  int bytes_sent = 0;
  int runs_expected = 0;
  int runs_clipped = 0;
  int status_hist[4] = '{0, 0, 0, 0};
  int stall_cycles = 0;
  int idle_cycles = 0;

  function automatic void add_expect(kind_t k, int widx, logic [63:0] v, int cnt,
                                     status_t st, logic lst);
    result_t r;
    r.kind        = k;
    r.word_index  = widx[1:0];
    r.value       = v;
    r.run_count   = cnt[8:0];
    r.status      = st;
    r.chunk_total = chunk_sum[TOTAL_W-1:0];
    r.last_of_msg = lst;
    expected_words.push_back(r);
  endfunction

  // Advance the shadow parser by one byte and queue the words it yields.
  function automatic void parse_byte(logic [7:0] b, logic eom);
    kind_t k;
    int unsigned fs, fl, f, n, cnt, room;
    status_t st;
    if (hdr_pos < HDR_BYTES) begin
      if (hdr_pos < OFS_PREV) begin
        k = KIND_ID; fs = 0; fl = 16;
      end else if (hdr_pos < OFS_INDEX) begin
        k = KIND_PREV_ID; fs = OFS_PREV; fl = 16;
      end else if (hdr_pos < OFS_HASH) begin
        k = KIND_INDEX; fs = OFS_INDEX; fl = 4;
      end else if (hdr_pos < OFS_NAME) begin
        k = KIND_HASH; fs = OFS_HASH; fl = HASH_BYTES;
      end else if (hdr_pos < OFS_ADDR) begin
        k = KIND_NAME; fs = OFS_NAME; fl = 31;
      end else if (hdr_pos < OFS_PORT) begin
        k = KIND_ADDR; fs = OFS_ADDR; fl = 4;
      end else begin
        k = KIND_PORT; fs = OFS_PORT; fl = 2;
      end
      f = hdr_pos - fs;
      word_acc[(f % 8) * 8 +: 8] = b;
      // A word closes on its eighth byte or on the last byte of its field.
      if ((f % 8) == 7 || f + 1 == fl) begin
        add_expect(k, f / 8, word_acc, 0, ST_SHORT, 1'b0);
        word_acc = '0;
      end
      hdr_pos++;
      n = hdr_pos;
    end else begin
      n = HDR_BYTES + 1;
      if (entry_bytes < 4) begin
        entry_addr[entry_bytes * 8 +: 8] = b;
        entry_bytes++;
      end else begin
        // Once the cap is reached, entries are consumed silently.
        if (chunk_sum < MAX_CHUNKS) begin
          cnt  = b + 1;
          room = MAX_CHUNKS - chunk_sum;
          if (cnt > room) begin
            cnt = room;
            runs_clipped++;
          end
          chunk_sum += cnt;
          runs_expected++;
          add_expect(KIND_RUN, 0, {32'h0, entry_addr}, cnt, ST_SHORT, 1'b0);
        end
        entry_bytes = 0;
        entry_addr  = '0;
      end
    end
    if (eom) begin
      if (n < ID_BYTES)       st = ST_SHORT;
      else if (n == ID_BYTES) st = ST_IDS_ONLY;
      else if (n < HDR_BYTES) st = ST_PARTIAL;
      else                    st = ST_COMPLETE;
      status_hist[st]++;
      add_expect(KIND_STATUS, 0, 64'h0, 0, st, 1'b1);
      // A trailing partial entry dies here along with the rest of the state.
      hdr_pos     = 0;
      word_acc    = '0;
      entry_bytes = 0;
      entry_addr  = '0;
      chunk_sum   = 0;
    end
  endfunction

  function automatic string show(result_t r);
    return $sformatf("kind=%0d widx=%0d value=%h cnt=%0d st=%0d total=%0d last=%0b",
                     r.kind, r.word_index, r.value, r.run_count, r.status,
                     r.chunk_total, r.last_of_msg);
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Queue one message of len bytes. With cap_runs set, run counts are chosen
  // so the cap is hit mid-run: 255 + 3 x 256 = 1023, next run clips to 1.
  task automatic queue_message(int len, bit cap_runs);
    msg_byte_t mb;
    int ofs;
    for (int i = 0; i < len; i++) begin
      ofs = i - HDR_BYTES;
      if (cap_runs && ofs >= 0 && (ofs % 5) == 4)
        mb.data = (ofs / 5 == 0) ? 8'hFE : 8'hFF;
      else
        mb.data = rand_byte();
      mb.eom = (i == len - 1);
      pending_bytes.push_back(mb);
    end
    bytes_sent += len;
    msgs_sent++;
  endtask

  // Mostly well-formed complete messages with runs; the rest truncated.
  task automatic queue_random_message(output int len);
    int sel;
    sel = $urandom_range(99);
    if (sel < 10)      len = $urandom_range(1, ID_BYTES - 1);
    else if (sel < 15) len = ID_BYTES;
    else if (sel < 30) len = $urandom_range(ID_BYTES + 1, HDR_BYTES - 1);
    else               len = HDR_BYTES + 5 * $urandom_range(0, 6) + $urandom_range(0, 4);
    queue_message(len, sel >= 30 && $urandom_range(4) == 0);
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || s_tvalid) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Byte driver: hold the current word until taken, then advance or idle.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    msg_byte_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) parse_byte(s_tdata, s_tlast);
      if (s_tvalid && !s_tready) stall_cycles++;
      if (!s_tvalid || s_tready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          nxt = pending_bytes.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= nxt.data;
          s_tlast  <= nxt.eom;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long hold-off counter, restarted on each new request.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_req != hold_seen) begin
      hold_left <= LONG_HOLD;
      hold_seen <= hold_req;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Sink ready: drop during a long hold, otherwise stall at the phase rate.
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else     m_tready <= (hold_left == 0) && ($urandom_range(99) >= dst_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Result monitor: compare each taken word with the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.kind        = kind_t'(m_tuser);
      got.word_index  = m_tdata[1:0];
      got.value       = m_tdata[65:2];
      got.run_count   = m_tdata[74:66];
      got.status      = status_t'(m_tdata[76:75]);
      got.chunk_total = m_tdata[87:77];
      got.last_of_msg = m_tlast;
      if (expected_words.size() == 0) begin
        if (fail_cnt < REPORT_MAX)
          $display("[%0t] unexpected word: %s", $realtime, show(got));
        fail_cnt++;
      end else begin
        want = expected_words.pop_front();
        words_checked++;
        if (got.kind !== want.kind || got.word_index !== want.word_index ||
            got.value !== want.value || got.run_count !== want.run_count ||
            got.status !== want.status || got.chunk_total !== want.chunk_total ||
            got.last_of_msg !== want.last_of_msg) begin
          if (fail_cnt < REPORT_MAX) begin
            $display("[%0t] mismatch", $realtime);
            $display("  expected: %s", show(want));
            $display("  actual:   %s", show(got));
          end
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog: count cycles with no handshake on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no traffic for %0d cycles, %0d words outstanding",
                 WATCHDOG_LIMIT, expected_words.size());
        $display("chunk_request_parser regression: fail");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus sequence.
  // --------------------------------------------------------------------------
  initial begin
    int len, added;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Phase 0, no idling. Directed messages first: single-byte extremes,
    // then an id word closing together with the status.
    pending_bytes.push_back('{data: 8'h00, eom: 1'b1});
    pending_bytes.push_back('{data: 8'hFF, eom: 1'b1});
    bytes_sent += 2;
    msgs_sent  += 2;
    queue_message(8, 1'b0);
    // Ids only; partial body ending on the file index word; bare header
    // ending on the port word; runs ending exactly on an entry; cap reached
    // with a clipped run, an ignored run and a trailing partial entry.
    queue_message(ID_BYTES, 1'b0);
    queue_message(OFS_HASH, 1'b0);
    queue_message(HDR_BYTES, 1'b0);
    queue_message(HDR_BYTES + 10, 1'b0);
    queue_message(HDR_BYTES + 30 + 2, 1'b1);
    // Hold the sink off while the source keeps offering, to back up the input.
    hold_req++;
    wait_drained();

    for (int ph = 1; ph <= 3; ph++) begin
      src_idle_pct  = (ph == 1) ? 75 : (ph == 3) ? 19 : 0;
      dst_stall_pct = (ph == 2) ? 75 : (ph == 3) ? 19 : 0;
      added = 0;
      while (added < PHASE_BYTES) begin
        queue_random_message(len);
        added += len;
      end
      wait_drained();
    end

    while (expected_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_words.size() != 0) fail_cnt += expected_words.size();

    $display("covered %0d messages / %0d bytes, %0d words checked (%0d runs, %0d clipped)",
             msgs_sent, bytes_sent, words_checked, runs_expected, runs_clipped);
    $display("status short/ids/partial/complete = %0d/%0d/%0d/%0d, input stalled %0d cycles",
             status_hist[0], status_hist[1], status_hist[2], status_hist[3], stall_cycles);
    if (fail_cnt == 0) begin
      $display("chunk_request_parser regression: pass");
    end else begin
      $display("%0d failures", fail_cnt);
      $display("chunk_request_parser regression: fail");
    end
    $finish;
  end

endmodule

### chunk_request_parser.f
rtl/crp_pkg.sv
rtl/crp_parse.sv
rtl/crp_outq.sv
rtl/chunk_request_parser.sv
tb/sv/tb_top.sv
